[rtl/core/sirq_pkg.sv]
// ----------------------------------------------------------------------------
// sirq_pkg: shared types and constants of the scanline interrupt unit
// Word layouts, register addresses, item kinds and the visible line limit.
// ----------------------------------------------------------------------------
`default_nettype none

package sirq_pkg;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [15:0] ADDR_SPLIT_SCROLL = 16'h5201;
    localparam logic [15:0] ADDR_IRQ_COMPARE  = 16'h5203;
    localparam logic [15:0] ADDR_IRQ_STATUS   = 16'h5204;
    localparam logic [15:0] ADDR_MUL_LO       = 16'h5205;
    localparam logic [15:0] ADDR_MUL_HI       = 16'h5206;

    localparam logic [8:0] VISIBLE_LINES = 9'd240;

    localparam logic [1:0] IDLE_MAX   = 2'd3;
    localparam logic [2:0] FINE_LAST  = 3'd7;
    localparam logic [4:0] ROW_WRAP_A = 5'd29;
    localparam logic [4:0] ROW_WRAP_B = 5'd31;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        display_on;
        logic [8:0]  line_number;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_level;
        logic [4:0] split_row;
        logic [2:0] split_fine_y;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/sirq_engine.sv]
// ----------------------------------------------------------------------------
// sirq_engine: state and update logic of the scanline interrupt unit
// Holds the counters and flags and computes the result of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module sirq_engine
    import sirq_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    alt_clear_mode,
    input  wire logic    fire,
    input  wire item_t   item,
    output result_t      result
);

    logic [7:0] line_count_reg, line_count_next;
    logic [7:0] compare_line_reg, compare_line_next;
    logic       irq_enable_reg, irq_enable_next;
    logic       pending_reg, pending_next;
    logic       in_frame_reg, in_frame_next;
    logic [1:0] idle_ticks_reg, idle_ticks_next;
    logic       irq_line_reg, irq_line_next;
    logic [7:0] factor_a_reg, factor_a_next;
    logic [7:0] factor_b_reg, factor_b_next;
    logic [7:0] split_scroll_reg, split_scroll_next;
    logic [4:0] split_row_reg, split_row_next;
    logic [2:0] split_fine_reg, split_fine_next;

    logic [15:0] product;
    logic [7:0]  read_data;
    logic        in_visible;

    assign product    = {8'd0, factor_a_reg} * {8'd0, factor_b_reg};
    assign in_visible = item.display_on && (item.line_number < VISIBLE_LINES);

    always_comb begin
        line_count_next   = line_count_reg;
        compare_line_next = compare_line_reg;
        irq_enable_next   = irq_enable_reg;
        pending_next      = pending_reg;
        in_frame_next     = in_frame_reg;
        idle_ticks_next   = idle_ticks_reg;
        irq_line_next     = irq_line_reg;
        factor_a_next     = factor_a_reg;
        factor_b_next     = factor_b_reg;
        split_scroll_next = split_scroll_reg;
        split_row_next    = split_row_reg;
        split_fine_next   = split_fine_reg;
        read_data         = 8'd0;

        case (item.kind)
            KIND_READ: begin
                read_data = item.addr[15:8];
                if (item.addr == ADDR_IRQ_STATUS) begin
                    read_data     = {pending_reg, in_frame_reg, 6'd0};
                    pending_next  = 1'b0;
                    irq_line_next = 1'b0;
                end else if (item.addr == ADDR_MUL_LO) begin
                    read_data = product[7:0];
                end else if (item.addr == ADDR_MUL_HI) begin
                    read_data = product[15:8];
                end
            end
            KIND_WRITE: begin
                case (item.addr)
                    ADDR_SPLIT_SCROLL: split_scroll_next = item.wdata;
                    ADDR_IRQ_COMPARE: begin
                        compare_line_next = item.wdata;
                        irq_line_next     = 1'b0;
                    end
                    ADDR_IRQ_STATUS: begin
                        irq_enable_next = item.wdata[7];
                        irq_line_next   = 1'b0;
                    end
                    ADDR_MUL_LO: factor_a_next = item.wdata;
                    ADDR_MUL_HI: factor_b_next = item.wdata;
                    default: ;
                endcase
            end
            KIND_TICK: begin
                // alternate rule compares before the count moves
                if (alt_clear_mode && (line_count_reg == compare_line_reg)) begin
                    pending_next = 1'b1;
                end
                if (in_visible) begin
                    line_count_next = line_count_reg + 8'd1;
                    in_frame_next   = 1'b1;
                    idle_ticks_next = 2'd0;
                end else if (alt_clear_mode) begin
                    line_count_next = 8'd0;
                    pending_next    = 1'b0;
                    in_frame_next   = 1'b0;
                end
                if (!alt_clear_mode) begin
                    if (line_count_next == compare_line_reg) begin
                        pending_next = 1'b1;
                    end
                    if (idle_ticks_next != IDLE_MAX) begin
                        idle_ticks_next = idle_ticks_next + 2'd1;
                    end
                    // second idle tick in a row after a visible line ends the frame
                    if (idle_ticks_next == IDLE_MAX) begin
                        line_count_next = 8'd0;
                        pending_next    = 1'b0;
                        in_frame_next   = 1'b0;
                        irq_line_next   = 1'b0;
                    end
                end
                if (irq_enable_reg && pending_next && in_frame_next) begin
                    irq_line_next = 1'b1;
                end

                if (item.line_number == 9'd0) begin
                    split_fine_next = split_scroll_reg[2:0];
                    split_row_next  = split_scroll_reg[7:3];
                end else if (item.display_on) begin
                    if (split_fine_reg == FINE_LAST) begin
                        split_fine_next = 3'd0;
                        if (split_row_reg == ROW_WRAP_A || split_row_reg == ROW_WRAP_B) begin
                            split_row_next = 5'd0;
                        end else begin
                            split_row_next = split_row_reg + 5'd1;
                        end
                    end else begin
                        split_fine_next = split_fine_reg + 3'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_count_reg   <= 8'd0;
            compare_line_reg <= 8'd0;
            irq_enable_reg   <= 1'b0;
            pending_reg      <= 1'b0;
            in_frame_reg     <= 1'b0;
            idle_ticks_reg   <= 2'd0;
            irq_line_reg     <= 1'b0;
            factor_a_reg     <= 8'd0;
            factor_b_reg     <= 8'd0;
            split_scroll_reg <= 8'd0;
            split_row_reg    <= 5'd0;
            split_fine_reg   <= 3'd0;
        end else if (fire) begin
            line_count_reg   <= line_count_next;
            compare_line_reg <= compare_line_next;
            irq_enable_reg   <= irq_enable_next;
            pending_reg      <= pending_next;
            in_frame_reg     <= in_frame_next;
            idle_ticks_reg   <= idle_ticks_next;
            irq_line_reg     <= irq_line_next;
            factor_a_reg     <= factor_a_next;
            factor_b_reg     <= factor_b_next;
            split_scroll_reg <= split_scroll_next;
            split_row_reg    <= split_row_next;
            split_fine_reg   <= split_fine_next;
        end
    end

    assign result.read_data    = read_data;
    assign result.irq_level    = irq_line_next;
    assign result.split_row    = split_row_next;
    assign result.split_fine_y = split_fine_next;

endmodule

`default_nettype wire

[rtl/core/scanline_irq_split_counter.sv]
// ----------------------------------------------------------------------------
// scanline_irq_split_counter: scanline interrupt and split-screen counter
// Bus reads, bus writes and sync ticks in; one result word per item out.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one item per word: a register read, a register
//   write or a horizontal-sync tick, selected by s_tuser. Every accepted
//   word yields exactly one m_ word with the read byte (zero for writes and
//   ticks), the interrupt line level and the split tile row and fine row.
//   cfg_valid/cfg_data write the clear-mode bit; cfg_ready is always high
//   and the bit should only change while no words are in flight.
//   An accepted word is loaded into the input register and then, once the
//   output side is free, its result is loaded into the result register.
//   Throughput is one word per cycle while the result words are taken.
//   When m_tready is low the result word holds, the input register still
//   takes one more word, and then s_tready drops until the result is taken.
//   Synchronous reset clears both stages, all counters and flags and the
//   clear-mode bit; s_tready is high as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module scanline_irq_split_counter
    import sirq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // addr[15:0], wdata[23:16], display_on[24], line_number[33:25], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // kind[1:0]
    input  wire logic [S_TUSER_W-1:0] s_tuser,

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // read_data[7:0], irq_level[8], split_row[13:9], split_fine_y[16:14], zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_data
);

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    logic       alt_mode_reg;

    logic       out_free;
    logic       fire;
    result_t    result;

    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            alt_mode_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_valid) begin
                alt_mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.kind        <= s_tuser[1:0];
            in_item_reg.addr        <= s_tdata[15:0];
            in_item_reg.wdata       <= s_tdata[23:16];
            in_item_reg.display_on  <= s_tdata[24];
            in_item_reg.line_number <= s_tdata[33:25];
        end
        if (fire) begin
            out_result_reg <= result;
        end
    end

    sirq_engine u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .alt_clear_mode (alt_mode_reg),
        .fire           (fire),
        .item           (in_item_reg),
        .result         (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_result_reg.split_fine_y,
                       out_result_reg.split_row,
                       out_result_reg.irq_level,
                       out_result_reg.read_data};

endmodule

`default_nettype wire

[rtl/core/sirq_checker.sv]
// ----------------------------------------------------------------------------
// sirq_checker: port-level checks of the scanline interrupt unit
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sirq_checker
    import sirq_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // result word is empty right after a reset cycle
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // a draining output always leaves room on the input side
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:17] == '0)
        else $error("result padding bits not zero");

endmodule

bind scanline_irq_split_counter sirq_checker u_sirq_checker (.*);

`default_nettype wire
